// ----- rtl/lcm_pkg.sv -----
// Shared constants and types for the letterbox coordinate mapper.
package lcm_pkg;

    localparam int SQUARE_DIM_DEF  = 640;
    localparam int SRC_DIM_MAX_DEF = 4096;

    localparam int REG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int POS_W      = 10;
    localparam int COL_W      = 12;
    localparam int ADDR_W     = 26;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    localparam logic [REG_W-1:0] SRC_WIDTH_RST  = 13'd640;
    localparam logic [REG_W-1:0] SRC_HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } t_reg_idx;

endpackage

// ----- rtl/lcm_div_cell.sv -----
// One restoring-division cell with two lanes sharing a divisor, plus a side payload.
module lcm_div_cell #(
    parameter int RW = 11,
    parameter int QW = 13,
    parameter int PW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [RW-1:0] i_div,
    input  logic [RW-1:0] i_rem_a,
    input  logic [QW-1:0] i_dvd_a,
    input  logic [RW-1:0] i_rem_b,
    input  logic [QW-1:0] i_dvd_b,
    input  logic [PW-1:0] i_pay,
    output logic [RW-1:0] o_rem_a,
    output logic [QW-1:0] o_dvd_a,
    output logic [RW-1:0] o_rem_b,
    output logic [QW-1:0] o_dvd_b,
    output logic [PW-1:0] o_pay
);

    logic [RW:0]   w_try_a;
    logic [RW:0]   w_try_b;
    logic [RW:0]   w_diff_a;
    logic [RW:0]   w_diff_b;
    logic          w_ge_a;
    logic          w_ge_b;
    logic [RW-1:0] r_rem_a;
    logic [QW-1:0] r_dvd_a;
    logic [RW-1:0] r_rem_b;
    logic [QW-1:0] r_dvd_b;
    logic [PW-1:0] r_pay;
    logic [RW-1:0] n_rem_a;
    logic [QW-1:0] n_dvd_a;
    logic [RW-1:0] n_rem_b;
    logic [QW-1:0] n_dvd_b;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    // The quotient bit shifts into the low end of the dividend word.
    always_comb begin
        w_try_a  = {i_rem_a, i_dvd_a[QW-1]};
        w_try_b  = {i_rem_b, i_dvd_b[QW-1]};
        w_diff_a = w_try_a - {1'b0, i_div};
        w_diff_b = w_try_b - {1'b0, i_div};
        w_ge_a   = (w_try_a >= {1'b0, i_div});
        w_ge_b   = (w_try_b >= {1'b0, i_div});
        n_rem_a  = w_ge_a ? w_diff_a[RW-1:0] : w_try_a[RW-1:0];
        n_rem_b  = w_ge_b ? w_diff_b[RW-1:0] : w_try_b[RW-1:0];
        n_dvd_a  = {i_dvd_a[QW-2:0], w_ge_a};
        n_dvd_b  = {i_dvd_b[QW-2:0], w_ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_a <= n_rem_a;
            r_dvd_a <= n_dvd_a;
            r_rem_b <= n_rem_b;
            r_dvd_b <= n_dvd_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pay <= '0;
        end else if (i_en) begin
            r_pay <= i_pay;
        end
    end

    assign o_rem_a = r_rem_a;
    assign o_dvd_a = r_dvd_a;
    assign o_rem_b = r_rem_b;
    assign o_dvd_b = r_dvd_b;
    assign o_pay   = r_pay;

endmodule

// ----- rtl/lcm_div_row.sv -----
// A row of division cells, one quotient bit per cell, moving one step per enabled cycle.
module lcm_div_row #(
    parameter int RW = 11,
    parameter int QW = 13,
    parameter int PW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [RW-1:0] i_div,
    input  logic [RW-1:0] i_rem_a,
    input  logic [QW-1:0] i_dvd_a,
    input  logic [RW-1:0] i_rem_b,
    input  logic [QW-1:0] i_dvd_b,
    input  logic [PW-1:0] i_pay,
    output logic [QW-1:0] o_quo_a,
    output logic [QW-1:0] o_quo_b,
    output logic [PW-1:0] o_pay
);

    logic [RW-1:0] w_rem_a [0:QW];
    logic [QW-1:0] w_dvd_a [0:QW];
    logic [RW-1:0] w_rem_b [0:QW];
    logic [QW-1:0] w_dvd_b [0:QW];
    logic [PW-1:0] w_pay   [0:QW];

    assign w_rem_a[0] = i_rem_a;
    assign w_dvd_a[0] = i_dvd_a;
    assign w_rem_b[0] = i_rem_b;
    assign w_dvd_b[0] = i_dvd_b;
    assign w_pay[0]   = i_pay;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        lcm_div_cell #(
            .RW (RW),
            .QW (QW),
            .PW (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_div   (i_div),
            .i_rem_a (w_rem_a[k]),
            .i_dvd_a (w_dvd_a[k]),
            .i_rem_b (w_rem_b[k]),
            .i_dvd_b (w_dvd_b[k]),
            .i_pay   (w_pay[k]),
            .o_rem_a (w_rem_a[k+1]),
            .o_dvd_a (w_dvd_a[k+1]),
            .o_rem_b (w_rem_b[k+1]),
            .o_dvd_b (w_dvd_b[k+1]),
            .o_pay   (w_pay[k+1])
        );
    end

    // The final remainders are not needed; only the quotients leave the row.
    assign o_quo_a = w_dvd_a[QW];
    assign o_quo_b = w_dvd_b[QW];
    assign o_pay   = w_pay[QW];

endmodule

// ----- rtl/letterbox_coordinate_mapper.sv -----
// Top level of the letterbox coordinate mapper: config, geometry row, item pipeline.
//
//  Channel   | Direction | Contents (lowest bits first)
//  ----------+-----------+------------------------------------------------------------
//  cfg       | in        | i_cfg_we, i_cfg_addr (0 width, 1 height), i_cfg_wdata 13 bits
//  s_axis    | in        | tdata: out_x[9:0], out_y[19:10], zero fill to 24 bits
//  m_axis    | out       | tdata: src_col, src_row, src_byte_addr, fill; tuser: is_padding
//
// A request can enter every cycle unless the pipeline is held or the geometry is settling;
// the depth of the pipeline is set by the division row, one cell per quotient bit of the
// source coordinate.
// After reset and after every register write, s_axis_tready stays low while the geometry
// row recomputes the scaled size and offsets.
// When m_axis_tready is low with a result waiting, the whole pipeline holds and s_axis_tready
// drops; the output register lets a new request enter while a result is still being taken.
module letterbox_coordinate_mapper #(
    parameter int SQUARE_DIM  = lcm_pkg::SQUARE_DIM_DEF,
    parameter int SRC_DIM_MAX = lcm_pkg::SRC_DIM_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcm_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [lcm_pkg::REG_W-1:0]         i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // out_x [9:0], out_y [19:10], zeros above
    input  logic [lcm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // src_col [11:0], src_row [23:12], src_byte_addr [49:24], zeros above
    output logic [lcm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // is_padding [0]
    output logic                              m_axis_tuser
);

    // Width of a source dimension, of a clamped source index, of the target size,
    // and of a position offset inside the target square.
    localparam int MW    = $clog2(SRC_DIM_MAX + 1);
    localparam int CW    = $clog2(SRC_DIM_MAX);
    localparam int DTW   = $clog2(SQUARE_DIM + 1);
    localparam int TW    = $clog2(SQUARE_DIM);
    localparam int CMP_W = (DTW > lcm_pkg::POS_W) ? DTW : lcm_pkg::POS_W;
    localparam int DN    = TW + MW;
    localparam int DD    = MW + DTW;
    localparam int SUM_W = CW + MW + 1;
    localparam int AX_W  = (SUM_W + 2 > lcm_pkg::ADDR_W) ? SUM_W + 2 : lcm_pkg::ADDR_W;
    localparam int LAT   = DTW + 3;
    localparam int CNT_W = $clog2(LAT + 1);
    localparam int FILL_W = lcm_pkg::OUT_DATA_W - 2 * lcm_pkg::COL_W - lcm_pkg::ADDR_W;

    localparam logic [DTW-1:0]   T_VAL  = DTW'(SQUARE_DIM);
    localparam logic [lcm_pkg::REG_W-1:0] MAX_REG = lcm_pkg::REG_W'(SRC_DIM_MAX);

    // ------------------------------------------------------------------
    // Configuration registers and the settle counter.
    // ------------------------------------------------------------------
    logic [lcm_pkg::REG_W-1:0] r_src_width;
    logic [lcm_pkg::REG_W-1:0] r_src_height;
    logic [CNT_W-1:0]          r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= lcm_pkg::SRC_WIDTH_RST;
            r_src_height <= lcm_pkg::SRC_HEIGHT_RST;
            r_settle     <= CNT_W'(LAT);
        end else if (i_cfg_we) begin
            case (lcm_pkg::t_reg_idx'(i_cfg_addr))
                lcm_pkg::REG_SRC_WIDTH: begin
                    r_src_width <= i_cfg_wdata;
                end
                lcm_pkg::REG_SRC_HEIGHT: begin
                    r_src_height <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
            r_settle <= CNT_W'(LAT);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Geometry: effective sizes, then new size = dim * T / max through a
    // division row, then the centered offset and end of the scaled area.
    // This path runs every cycle; the values settle before any request enters.
    // ------------------------------------------------------------------
    logic [MW-1:0] w_weff;
    logic [MW-1:0] w_heff;
    logic [MW-1:0] r_d1_w;
    logic [MW-1:0] r_d1_h;
    logic [MW-1:0] r_d1_m;
    logic [DD-1:0] r_d2_wt;
    logic [DD-1:0] r_d2_ht;
    logic [MW-1:0] r_d2_m;
    logic [MW-1:0] r_d2_w;
    logic [MW-1:0] r_d2_h;

    // A zero size counts as one and a size above the maximum saturates.
    always_comb begin
        if (r_src_width == '0) begin
            w_weff = MW'(1);
        end else if (r_src_width > MAX_REG) begin
            w_weff = MW'(SRC_DIM_MAX);
        end else begin
            w_weff = r_src_width[MW-1:0];
        end
        if (r_src_height == '0) begin
            w_heff = MW'(1);
        end else if (r_src_height > MAX_REG) begin
            w_heff = MW'(SRC_DIM_MAX);
        end else begin
            w_heff = r_src_height[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_w  <= w_weff;
        r_d1_h  <= w_heff;
        r_d1_m  <= (w_weff > w_heff) ? w_weff : w_heff;
        r_d2_wt <= DD'(r_d1_w) * DD'(T_VAL);
        r_d2_ht <= DD'(r_d1_h) * DD'(T_VAL);
        r_d2_m  <= r_d1_m;
        r_d2_w  <= r_d1_w;
        r_d2_h  <= r_d1_h;
    end

    logic [DTW-1:0]    w_new_w;
    logic [DTW-1:0]    w_new_h;
    logic [3*MW-1:0]   w_geo_pay;
    logic [DTW-1:0]    w_off_x;
    logic [DTW-1:0]    w_off_y;
    logic [DTW-1:0]    r_off_x;
    logic [DTW-1:0]    r_off_y;
    logic [DTW-1:0]    r_end_x;
    logic [DTW-1:0]    r_end_y;
    logic [MW-1:0]     r_wf;
    logic [MW-1:0]     r_hf;
    logic [MW-1:0]     r_mf;

    // The quotient is at most T, so the upper dividend bits start out below max.
    lcm_div_row #(
        .RW (MW),
        .QW (DTW),
        .PW (3 * MW)
    ) u_geo_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (1'b1),
        .i_div   (r_d2_m),
        .i_rem_a (r_d2_wt[DD-1:DTW]),
        .i_dvd_a (r_d2_wt[DTW-1:0]),
        .i_rem_b (r_d2_ht[DD-1:DTW]),
        .i_dvd_b (r_d2_ht[DTW-1:0]),
        .i_pay   ({r_d2_m, r_d2_h, r_d2_w}),
        .o_quo_a (w_new_w),
        .o_quo_b (w_new_h),
        .o_pay   (w_geo_pay)
    );

    assign w_off_x = (T_VAL - w_new_w) >> 1;
    assign w_off_y = (T_VAL - w_new_h) >> 1;

    always_ff @(posedge i_clk) begin
        r_off_x <= w_off_x;
        r_off_y <= w_off_y;
        r_end_x <= w_off_x + w_new_w;
        r_end_y <= w_off_y + w_new_h;
        r_wf    <= w_geo_pay[MW-1:0];
        r_hf    <= w_geo_pay[2*MW-1:MW];
        r_mf    <= w_geo_pay[3*MW-1:2*MW];
    end

    // ------------------------------------------------------------------
    // Request pipeline. Every stage moves together; it holds only when the
    // output register is full and the far side is not taking it.
    // ------------------------------------------------------------------
    logic w_en;
    logic w_accept;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en && (r_settle == '0);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Stage 1: capture the coordinates.
    logic                      r1_v;
    logic [lcm_pkg::POS_W-1:0] r1_x;
    logic [lcm_pkg::POS_W-1:0] r1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x <= s_axis_tdata[lcm_pkg::POS_W-1:0];
            r1_y <= s_axis_tdata[2*lcm_pkg::POS_W-1:lcm_pkg::POS_W];
        end
    end

    // Stage 2: border test and the product (pos - offset) * max.
    logic [CMP_W-1:0] w_px;
    logic [CMP_W-1:0] w_py;
    logic [CMP_W-1:0] w_dx_full;
    logic [CMP_W-1:0] w_dy_full;
    logic             w_in_x;
    logic             w_in_y;
    logic             r2_v;
    logic             r2_pad;
    logic [DN-1:0]    r2_px;
    logic [DN-1:0]    r2_py;

    always_comb begin
        w_px      = CMP_W'(r1_x);
        w_py      = CMP_W'(r1_y);
        w_in_x    = (w_px >= CMP_W'(r_off_x)) && (w_px < CMP_W'(r_end_x));
        w_in_y    = (w_py >= CMP_W'(r_off_y)) && (w_py < CMP_W'(r_end_y));
        w_dx_full = w_px - CMP_W'(r_off_x);
        w_dy_full = w_py - CMP_W'(r_off_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    // Inside the scaled area the offset from its edge is below T.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pad <= !(w_in_x && w_in_y);
            r2_px  <= DN'(w_dx_full[TW-1:0]) * DN'(r_mf);
            r2_py  <= DN'(w_dy_full[TW-1:0]) * DN'(r_mf);
        end
    end

    // Division by T, one source-coordinate bit per cell. The product is below
    // T * max, so its bits above the quotient width start out below T.
    logic [MW-1:0] w_qx;
    logic [MW-1:0] w_qy;
    logic [1:0]    w_item_pay;

    lcm_div_row #(
        .RW (DTW),
        .QW (MW),
        .PW (2)
    ) u_item_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_div   (T_VAL),
        .i_rem_a (DTW'(r2_px[DN-1:MW])),
        .i_dvd_a (r2_px[MW-1:0]),
        .i_rem_b (DTW'(r2_py[DN-1:MW])),
        .i_dvd_b (r2_py[MW-1:0]),
        .i_pay   ({r2_pad, r2_v}),
        .o_quo_a (w_qx),
        .o_quo_b (w_qy),
        .o_pay   (w_item_pay)
    );

    // Stage 3: clamp to the last column and row.
    logic [MW-1:0] w_wlim;
    logic [MW-1:0] w_hlim;
    logic          r3_v;
    logic          r3_pad;
    logic [CW-1:0] r3_sc;
    logic [CW-1:0] r3_sr;

    assign w_wlim = r_wf - MW'(1);
    assign w_hlim = r_hf - MW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_item_pay[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_pad <= w_item_pay[1];
            r3_sc  <= (w_qx > w_wlim) ? w_wlim[CW-1:0] : w_qx[CW-1:0];
            r3_sr  <= (w_qy > w_hlim) ? w_hlim[CW-1:0] : w_qy[CW-1:0];
        end
    end

    // Stage 4: row * width. Stage 5: plus column.
    logic                 r4_v;
    logic                 r4_pad;
    logic [CW-1:0]        r4_sc;
    logic [CW-1:0]        r4_sr;
    logic [CW+MW-1:0]     r4_prod;
    logic                 r5_v;
    logic                 r5_pad;
    logic [CW-1:0]        r5_sc;
    logic [CW-1:0]        r5_sr;
    logic [SUM_W-1:0]     r5_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_pad  <= r3_pad;
            r4_sc   <= r3_sc;
            r4_sr   <= r3_sr;
            r4_prod <= (CW + MW)'(r3_sr) * (CW + MW)'(r_wf);
            r5_pad  <= r4_pad;
            r5_sc   <= r4_sc;
            r5_sr   <= r4_sr;
            r5_sum  <= SUM_W'(r4_prod) + SUM_W'(r4_sc);
        end
    end

    // Output register: times three for RGB, zeros on a border pixel.
    logic [AX_W-1:0]             w_sum_ext;
    logic [AX_W-1:0]             w_addr3;
    logic                        r_out_v;
    logic                        r_out_pad;
    logic [lcm_pkg::COL_W-1:0]   r_out_col;
    logic [lcm_pkg::COL_W-1:0]   r_out_row;
    logic [lcm_pkg::ADDR_W-1:0]  r_out_addr;

    assign w_sum_ext = AX_W'(r5_sum);
    assign w_addr3   = (w_sum_ext << 1) + w_sum_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pad <= r5_pad;
            if (r5_pad) begin
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_addr <= '0;
            end else begin
                r_out_col  <= lcm_pkg::COL_W'(r5_sc);
                r_out_row  <= lcm_pkg::COL_W'(r5_sr);
                r_out_addr <= w_addr3[lcm_pkg::ADDR_W-1:0];
            end
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_pad;
    assign m_axis_tdata  = {FILL_W'(0), r_out_addr, r_out_row, r_out_col};

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the letterbox coordinate mapper with its own mapping predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcm_pkg::*;

    // Geometry of the instance under test; the block runs with its default parameters.
    localparam int unsigned TGT     = SQUARE_DIM_DEF;
    localparam int unsigned DIM_CAP = SRC_DIM_MAX_DEF;

    // Cycles of quiet before a register write. The mapping pipeline is 19 deep, so this much
    // quiet with nothing outstanding means the block has fully drained.
    localparam int SETTLE_CYC  = 25;
    // One long stretch in which the receiver refuses results, so the pipeline backs up.
    localparam int LONG_HOLD   = 300;
    // No request, result or register write for this many cycles means the block has hung.
    // The longest stretch a correct run can see is the long hold plus one sender gap.
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 112;
    localparam int RAND_PHASES = 13;
    localparam int MAX_REPORTS = 10;

    // Entries of the plan that feeds the driver.
    typedef enum logic [1:0] {
        OP_ITEM,    // one coordinate request
        OP_CFG,     // register write, issued once the block is idle
        OP_DRAIN    // sender pauses until every outstanding result has come back
    } t_op_kind;

    typedef struct {
        t_op_kind         kind;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        t_reg_idx         idx;
        logic [REG_W-1:0] val;
    } t_req;

    // One mapped pixel as the block reports it.
    typedef struct packed {
        logic             pad;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        logic [ADDR_W-1:0] addr;
    } t_src_pix;

    // Extreme register settings visited by the first random phases.
    localparam logic [REG_W-1:0] EXT_W [6] = '{13'd1, 13'd4096, 13'd4096, 13'd1, 13'd0, 13'd8191};
    localparam logic [REG_W-1:0] EXT_H [6] = '{13'd1, 13'd4096, 13'd1, 13'd4096, 13'd8191, 13'd0};

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [REG_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // Predictor state: its own copy of the two size registers.
    logic [REG_W-1:0] width_q  = SRC_WIDTH_RST;
    logic [REG_W-1:0] height_q = SRC_HEIGHT_RST;

    t_req     req_plan_q [$];
    t_src_pix want_pix_q [$];

    // Handshake bookkeeping, all updated at the rising edge.
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    int   tx_count = 0;
    int   bad_cnt  = 0;
    int   stuck_cyc = 0;

    // Driver and receiver pacing, each owned by its own process.
    int   tx_wait = 0;
    int   rx_wait = 0;
    int   quiet   = 0;
    bit   tx_burst = 1'b0;
    bit   rx_burst = 1'b0;
    bit   hold_asked = 1'b0;
    bit   long_hold_done = 1'b0;
    logic rx_hold_req = 1'b0;

    // Register values the stimulus side has scheduled so far.
    logic [REG_W-1:0] plan_w = SRC_WIDTH_RST;
    logic [REG_W-1:0] plan_h = SRC_HEIGHT_RST;

    letterbox_coordinate_mapper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // A zero size acts as one pixel and anything past the maximum is clipped to it.
    function automatic int unsigned eff_dim(input logic [REG_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_CAP) return DIM_CAP;
        return 32'(v);
    endfunction

    // Length of one side after scaling so that the longer side fills the square.
    function automatic int unsigned fit_len(input int unsigned d, input int unsigned o);
        return d * TGT / ((d > o) ? d : o);
    endfunction

    // True when pos falls inside the centered span of length len; src then gets the
    // source index rounded down, clipped to the last pixel of the side.
    function automatic bit axis_hit(input int unsigned pos, input int unsigned len,
                                    input int unsigned dim, input int unsigned m,
                                    output int unsigned src);
        int unsigned off;
        off = (TGT - len) / 2;
        src = 0;
        if (pos < off || pos >= off + len) return 1'b0;
        src = (pos - off) * m / TGT;
        if (src >= dim) src = dim - 1;
        return 1'b1;
    endfunction

    // Predicts the result for one output coordinate under the given register values.
    function automatic t_src_pix map_to_source(input logic [POS_W-1:0] x,
                                               input logic [POS_W-1:0] y,
                                               input logic [REG_W-1:0] wr,
                                               input logic [REG_W-1:0] hr);
        int unsigned w, h, m, sc, sr;
        bit hx, hy;
        t_src_pix p;
        w = eff_dim(wr);
        h = eff_dim(hr);
        m = (w > h) ? w : h;
        hx = axis_hit(x, fit_len(w, h), w, m, sc);
        hy = axis_hit(y, fit_len(h, w), h, m, sr);
        p = '0;
        if (hx && hy) begin
            p.col  = sc[COL_W-1:0];
            p.row  = sr[COL_W-1:0];
            p.addr = ADDR_W'((sr * w + sc) * 3);
        end else begin
            // Border pixels report padding and all-zero source fields.
            p.pad = 1'b1;
        end
        return p;
    endfunction

    // Per-request wait of one side; now and then the side switches between gapped
    // traffic and back-to-back bursts.
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 31) == 0) burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 16));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus plan helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input int unsigned x, input int unsigned y);
        req_plan_q.push_back('{OP_ITEM, POS_W'(x), POS_W'(y), REG_SRC_WIDTH, '0});
    endtask

    task automatic queue_cfg(input t_reg_idx idx, input logic [REG_W-1:0] val);
        req_plan_q.push_back('{OP_CFG, '0, '0, idx, val});
        if (idx == REG_SRC_WIDTH) plan_w = val;
        else plan_h = val;
    endtask

    // Picks one coordinate just around an edge of the scaled picture on one axis.
    function automatic int unsigned near_edge(input int unsigned off, input int unsigned len);
        case ($urandom_range(0, 3))
            0: return (off > 0) ? off - 1 : 0;
            1: return off;
            2: return (len > 0) ? off + len - 1 : off;
            default: return off + len;
        endcase
    endfunction

    // First and last pixels of the scaled picture and the border pixels right beside them.
    task automatic queue_edges();
        int unsigned w, h, nw, nh, ox, oy;
        w  = eff_dim(plan_w);
        h  = eff_dim(plan_h);
        nw = fit_len(w, h);
        nh = fit_len(h, w);
        ox = (TGT - nw) / 2;
        oy = (TGT - nh) / 2;
        queue_item(ox, oy);
        queue_item(ox + nw - 1, oy + nh - 1);
        queue_item(ox + nw, oy);
        queue_item(ox, oy + nh);
        queue_item((ox > 0) ? ox - 1 : 1023, oy + nh - 1);
        queue_item(ox + nw - 1, (oy > 0) ? oy - 1 : 1023);
    endtask

    // Random size register value: mostly legal, some tiny, some anywhere in 13 bits.
    function automatic logic [REG_W-1:0] rand_dim();
        case ($urandom_range(0, 3))
            0: return REG_W'($urandom_range(1, 64));
            1: return REG_W'($urandom_range(0, 8191));
            default: return REG_W'($urandom_range(1, 4096));
        endcase
    endfunction

    // One random phase under the scheduled sizes. Most requests land in the picture so
    // the division path is well exercised; the rest hit edges, the border and the area
    // beyond the square. The sender drains once in the middle of every phase.
    task automatic queue_random_phase();
        int unsigned w, h, nw, nh, ox, oy, pw, ph, x, y, r, n, run;
        bit drained;
        w  = eff_dim(plan_w);
        h  = eff_dim(plan_h);
        nw = fit_len(w, h);
        nh = fit_len(h, w);
        ox = (TGT - nw) / 2;
        oy = (TGT - nh) / 2;
        pw = (nw == 0) ? 1 : nw;
        ph = (nh == 0) ? 1 : nh;
        n = 0;
        drained = 1'b0;
        while (n < PHASE_ITEMS) begin
            if (!drained && n >= PHASE_ITEMS / 2) begin
                drained = 1'b1;
                req_plan_q.push_back('{OP_DRAIN, '0, '0, REG_SRC_WIDTH, '0});
            end
            run = 1;
            r = $urandom_range(0, 99);
            if (r < 55) begin
                x = ox + $urandom_range(0, pw - 1);
                y = oy + $urandom_range(0, ph - 1);
            end else if (r < 75) begin
                x = $urandom_range(0, TGT - 1);
                y = $urandom_range(0, TGT - 1);
            end else if (r < 87) begin
                x = near_edge(ox, nw);
                y = near_edge(oy, nh);
            end else if (r < 94) begin
                // A short raster run along one row, as a video front end would issue.
                x = $urandom_range(0, TGT - 1);
                y = oy + $urandom_range(0, ph - 1);
                run = 8;
            end else begin
                x = $urandom_range(0, 1023);
                y = $urandom_range(0, 1023);
            end
            for (int k = 0; k < run; k++) queue_item(x + k, y);
            n += run;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // Directed part under the reset sizes (640 x 480): picture edges, the corners of
        // the square and the far corner of the 10-bit coordinate space.
        queue_edges();
        queue_item(0, 0);
        queue_item(TGT - 1, 0);
        queue_item(0, TGT - 1);
        queue_item(TGT - 1, TGT - 1);
        queue_item(1023, 1023);
        // A width above the maximum with a zero height: clipped to 4096 by 1.
        queue_cfg(REG_SRC_WIDTH, 13'd8191);
        queue_cfg(REG_SRC_HEIGHT, 13'd0);
        queue_edges();

        // Random phases; the first ones walk through the extreme sizes.
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 6) begin
                queue_cfg(REG_SRC_WIDTH, EXT_W[p]);
                queue_cfg(REG_SRC_HEIGHT, EXT_H[p]);
            end else begin
                if ($urandom_range(0, 2) != 0) queue_cfg(REG_SRC_WIDTH, rand_dim());
                queue_cfg(REG_SRC_HEIGHT, rand_dim());
            end
            queue_edges();
            queue_random_phase();
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The watchdog ends the run if the block stops answering.
        while (req_plan_q.size() != 0 || s_axis_tvalid || want_pix_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (bad_cnt == 0 && want_pix_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: presents requests and register writes at the falling edge.
    // A request stays on the bus until the rising edge that takes it; the next one may
    // follow right away, so valid is written exactly once per edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_req                 op;
        logic                 nv;
        logic [IN_DATA_W-1:0] nd;
        logic                 nwe;
        logic [CFG_IDX_W-1:0] na;
        logic [REG_W-1:0]     nwd;
        bit                   run_ok;
        nv  = s_axis_tvalid && !in_fire;
        nd  = s_axis_tdata;
        nwe = 1'b0;
        na  = i_cfg_addr;
        nwd = i_cfg_wdata;
        if (!i_rst_n) begin
            nv = 1'b0;
            quiet = 0;
            tx_wait = 0;
        end else begin
            quiet = (want_pix_q.size() == 0) ? quiet + 1 : 0;
            if (in_fire) tx_wait = draw_wait(tx_burst);
            if (!nv) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (req_plan_q.size() != 0) begin
                    case (req_plan_q[0].kind)
                        OP_ITEM: begin
                            op = req_plan_q.pop_front();
                            nv = 1'b1;
                            nd = IN_DATA_W'({op.y, op.x});
                            // Once, well into the run and with a long stretch of requests
                            // ahead, ask the receiver to stop taking results.
                            if (!hold_asked && tx_count >= 400 && req_plan_q.size() > 50) begin
                                run_ok = 1'b1;
                                for (int i = 0; i < 50; i++)
                                    if (req_plan_q[i].kind != OP_ITEM) run_ok = 1'b0;
                                if (run_ok) begin
                                    hold_asked = 1'b1;
                                    rx_hold_req <= 1'b1;
                                end
                            end
                        end
                        OP_DRAIN: begin
                            if (want_pix_q.size() == 0) req_plan_q.delete(0);
                        end
                        OP_CFG: begin
                            // Quiet long enough implies every result is back and the
                            // pipeline is empty.
                            if (quiet >= SETTLE_CYC) begin
                                op = req_plan_q.pop_front();
                                nwe = 1'b1;
                                na  = op.idx;
                                nwd = op.val;
                                quiet = 0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
        i_cfg_we      <= nwe;
        i_cfg_addr    <= na;
        i_cfg_wdata   <= nwd;
    end

    // ------------------------------------------------------------------
    // Receiver: after each taken result it waits a drawn number of cycles. The one long
    // hold keeps ready low while the sender keeps offering, so the block must stall.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) rx_wait = draw_wait(rx_burst);
            if (rx_hold_req && !long_hold_done) begin
                rx_wait = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, predict every accepted request under the current
    // register copy, apply register writes, and check every accepted result in order.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_src_pix want;
        t_src_pix got;
        in_fire  <= s_axis_tvalid && s_axis_tready;
        out_fire <= m_axis_tvalid && m_axis_tready;
        if (!i_rst_n) begin
            width_q  <= SRC_WIDTH_RST;
            height_q <= SRC_HEIGHT_RST;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                want_pix_q.push_back(map_to_source(s_axis_tdata[POS_W-1:0],
                                                   s_axis_tdata[2*POS_W-1:POS_W],
                                                   width_q, height_q));
                tx_count <= tx_count + 1;
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_SRC_WIDTH) width_q <= i_cfg_wdata;
                else height_q <= i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.pad  = m_axis_tuser;
                got.col  = m_axis_tdata[COL_W-1:0];
                got.row  = m_axis_tdata[2*COL_W-1:COL_W];
                got.addr = m_axis_tdata[2*COL_W+ADDR_W-1:2*COL_W];
                if (want_pix_q.size() == 0) begin
                    if (bad_cnt < MAX_REPORTS)
                        $display("unexpected result at %0t: pad=%0d col=%0d row=%0d addr=%0d",
                                 $realtime, got.pad, got.col, got.row, got.addr);
                    bad_cnt++;
                end else begin
                    want = want_pix_q.pop_front();
                    if (got.pad !== want.pad || got.col !== want.col ||
                        got.row !== want.row || got.addr !== want.addr) begin
                        if (bad_cnt < MAX_REPORTS)
                            $display({"mismatch at %0t: expected pad=%0d col=%0d row=%0d ",
                                      "addr=%0d, got pad=%0d col=%0d row=%0d addr=%0d"},
                                     $realtime, want.pad, want.col, want.row, want.addr,
                                     got.pad, got.col, got.row, got.addr);
                        bad_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no request, result or register write is taken.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            stuck_cyc <= 0;
        else
            stuck_cyc <= stuck_cyc + 1;
        if (stuck_cyc >= STUCK_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
rtl/lcm_pkg.sv
rtl/lcm_div_cell.sv
rtl/lcm_div_row.sv
rtl/letterbox_coordinate_mapper.sv
tb/tb_top.sv
